// ----- hw/rtl/moving_average_deviation_assert.svh -----
// assertion macros used by the checker file mad_checker.sv
`ifndef MOVING_AVERAGE_DEVIATION_ASSERT_SVH
`define MOVING_AVERAGE_DEVIATION_ASSERT_SVH

// a stalled transaction keeps valid high and its payload unchanged
`define MAD_ASSERT_HOLD(label, vld, rdy, dat, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(dat))) else $error(msg);

// plain implication checked at every clock edge out of reset
`define MAD_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) else $error(msg);

`endif

// ----- hw/rtl/mad_pkg.sv -----
`timescale 1ns / 1ps

package mad_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int SAMPLE_BITS = 16;
    localparam int PTR_W       = $clog2(MAX_WINDOW);
    localparam int LEN_W       = 7;
    localparam int SUM_W       = SAMPLE_BITS + PTR_W;
    localparam int DEV_W       = SAMPLE_BITS + 1;
    localparam int DIV_CNT_W   = $clog2(SUM_W);
    localparam int IN_DATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_W  = ((SAMPLE_BITS + DEV_W + 7) / 8) * 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(8);

    typedef enum logic
    {
        OP_PUSH  = 1'b0,
        OP_CLEAR = 1'b1
    } op_kind_t;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_READ,
        ST_ABS,
        ST_DIV,
        ST_OUT
    } back_state_t;

    typedef struct packed
    {
        op_kind_t                       kind;
        logic signed [SAMPLE_BITS-1:0]  sample;
    } q_entry_t;

    typedef struct packed
    {
        logic     valid;
        q_entry_t entry;
    } q_item_t;

    // zero acts as one, anything past the ring depth acts as the depth
    function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
        logic [LEN_W-1:0] r;
        if (v == '0)
        begin
            r = LEN_W'(1);
        end
        else if (v > LEN_W'(MAX_WINDOW))
        begin
            r = LEN_W'(MAX_WINDOW);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/mad_ram.sv -----
`timescale 1ns / 1ps

module mad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/mad_front.sv -----
`timescale 1ns / 1ps

module mad_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mad_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    input  logic [0:0]                     s_axis_tuser,
    output mad_pkg::q_item_t               q_item,
    input  logic                           q_pop
);

    mad_pkg::q_entry_t               mem_reg [mad_pkg::QUEUE_DEPTH];
    logic [mad_pkg::QUEUE_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [mad_pkg::QUEUE_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [mad_pkg::QUEUE_CW-1:0]    count_reg, count_next;
    mad_pkg::q_entry_t               in_entry;
    logic                            push;
    logic                            pop;

    // classify the incoming transaction
    always_comb
    begin
        in_entry.kind   = s_axis_tuser[0] ? mad_pkg::OP_CLEAR : mad_pkg::OP_PUSH;
        in_entry.sample = s_axis_tdata[mad_pkg::SAMPLE_BITS-1:0];
    end

    assign s_axis_tready = (count_reg != mad_pkg::QUEUE_CW'(mad_pkg::QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign pop           = q_pop && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_entry;
        end
    end

    always_comb
    begin
        q_item.valid = (count_reg != '0);
        q_item.entry = mem_reg[rd_ptr_reg];
    end

endmodule

// ----- hw/rtl/mad_div.sv -----
`timescale 1ns / 1ps

module mad_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [mad_pkg::SUM_W-1:0]    dividend,
    input  logic [mad_pkg::LEN_W-1:0]    divisor,
    output logic                         done,
    output logic [mad_pkg::SUM_W-1:0]    quotient
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [mad_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [mad_pkg::SUM_W-1:0]       dvd_reg, dvd_next;
    logic [mad_pkg::LEN_W-1:0]       rem_reg, rem_next;
    logic [mad_pkg::LEN_W-1:0]       dsr_reg, dsr_next;
    logic [mad_pkg::LEN_W:0]         trial;
    logic [mad_pkg::LEN_W:0]         diff;
    logic                            ge;

    // restoring divide, one quotient bit per cycle shifted in behind the dividend
    always_comb
    begin
        trial = {rem_reg, dvd_reg[mad_pkg::SUM_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        ge    = (trial >= {1'b0, dsr_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next = {dvd_reg[mad_pkg::SUM_W-2:0], ge};
            rem_next = ge ? diff[mad_pkg::LEN_W-1:0] : trial[mad_pkg::LEN_W-1:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == mad_pkg::DIV_CNT_W'(mad_pkg::SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = dvd_reg;

endmodule

// ----- hw/rtl/mad_back.sv -----
`timescale 1ns / 1ps

module mad_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mad_pkg::LEN_W-1:0]      cfg_wr_data,
    input  mad_pkg::q_item_t               q_item,
    output logic                           q_pop,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mad_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    mad_pkg::back_state_t                    state_reg, state_next;
    logic [mad_pkg::LEN_W-1:0]               len_reg, len_next;
    logic [mad_pkg::PTR_W-1:0]               ptr_reg, ptr_next;
    logic [mad_pkg::MAX_WINDOW-1:0]          valid_reg, valid_next;
    logic signed [mad_pkg::SUM_W-1:0]        sum_reg, sum_next;
    logic signed [mad_pkg::SAMPLE_BITS-1:0]  x_reg, x_next;
    logic                                    clear_reg, clear_next;
    logic                                    neg_reg, neg_next;
    logic                                    out_valid_reg, out_valid_next;
    logic signed [mad_pkg::SAMPLE_BITS-1:0]  out_mean_reg, out_mean_next;
    logic signed [mad_pkg::DEV_W-1:0]        out_dev_reg, out_dev_next;

    logic [mad_pkg::LEN_W-1:0]               len_eff;
    logic [mad_pkg::PTR_W-1:0]               ptr_wrap;
    logic [mad_pkg::LEN_W-1:0]               ptr_inc;
    logic [mad_pkg::PTR_W-1:0]               ptr_adv;
    logic                                    ram_re;
    logic                                    ram_we;
    logic [mad_pkg::SAMPLE_BITS-1:0]         ram_rdata;
    logic signed [mad_pkg::SAMPLE_BITS-1:0]  old_sample;
    logic                                    div_start;
    logic                                    div_done;
    logic [mad_pkg::SUM_W-1:0]               div_dividend;
    logic [mad_pkg::SUM_W-1:0]               div_quotient;
    logic signed [mad_pkg::SAMPLE_BITS-1:0]  mean_val;
    logic                                    out_load;
    logic                                    is_clear;

    assign len_eff  = mad_pkg::eff_len(len_reg);
    assign ptr_wrap = (mad_pkg::LEN_W'(ptr_reg) >= len_eff) ? '0 : ptr_reg;
    assign ptr_inc  = mad_pkg::LEN_W'(ptr_reg) + 1'b1;
    assign ptr_adv  = (ptr_inc >= len_eff) ? '0 : ptr_inc[mad_pkg::PTR_W-1:0];
    assign is_clear = (q_item.entry.kind == mad_pkg::OP_CLEAR);

    mad_ram #(
        .WIDTH (mad_pkg::SAMPLE_BITS),
        .DEPTH (mad_pkg::MAX_WINDOW)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ptr_reg),
        .wdata (x_reg),
        .re    (ram_re),
        .raddr (ptr_wrap),
        .rdata (ram_rdata)
    );

    mad_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (len_eff),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            mad_pkg::ST_IDLE:
            begin
                if (q_item.valid)
                begin
                    state_next = is_clear ? mad_pkg::ST_OUT : mad_pkg::ST_READ;
                end
            end
            mad_pkg::ST_READ:
            begin
                state_next = mad_pkg::ST_ABS;
            end
            mad_pkg::ST_ABS:
            begin
                state_next = mad_pkg::ST_DIV;
            end
            mad_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = mad_pkg::ST_OUT;
                end
            end
            mad_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = mad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mad_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        q_pop     = 1'b0;
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (state_reg)
            mad_pkg::ST_IDLE:
            begin
                q_pop  = q_item.valid;
                ram_re = q_item.valid && !is_clear;
            end
            mad_pkg::ST_READ:
            begin
                ram_we = 1'b1;
            end
            mad_pkg::ST_ABS:
            begin
                div_start = 1'b1;
            end
            mad_pkg::ST_OUT:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // an entry never written since the last clear, length write or reset reads as zero
    assign old_sample   = valid_reg[ptr_reg] ? ram_rdata : '0;
    assign div_dividend = sum_reg[mad_pkg::SUM_W-1] ? -sum_reg : sum_reg;
    assign mean_val     = clear_reg ? '0 :
                          (neg_reg ? -div_quotient[mad_pkg::SAMPLE_BITS-1:0]
                                   : div_quotient[mad_pkg::SAMPLE_BITS-1:0]);

    always_comb
    begin
        len_next       = len_reg;
        ptr_next       = ptr_reg;
        valid_next     = valid_reg;
        sum_next       = sum_reg;
        x_next         = x_reg;
        clear_next     = clear_reg;
        neg_next       = neg_reg;
        out_mean_next  = out_mean_reg;
        out_dev_next   = out_dev_reg;
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            mad_pkg::ST_IDLE:
            begin
                if (q_item.valid)
                begin
                    clear_next = is_clear;
                    if (is_clear)
                    begin
                        x_next     = '0;
                        ptr_next   = '0;
                        valid_next = '0;
                        sum_next   = '0;
                    end
                    else
                    begin
                        x_next   = q_item.entry.sample;
                        ptr_next = ptr_wrap;
                    end
                end
            end
            mad_pkg::ST_READ:
            begin
                sum_next            = sum_reg - mad_pkg::SUM_W'(old_sample)
                                      + mad_pkg::SUM_W'(x_reg);
                valid_next[ptr_reg] = 1'b1;
                ptr_next            = ptr_adv;
            end
            mad_pkg::ST_ABS:
            begin
                neg_next = sum_reg[mad_pkg::SUM_W-1];
            end
            mad_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_mean_next  = mean_val;
                    out_dev_next   = mad_pkg::DEV_W'(mean_val) - mad_pkg::DEV_W'(x_reg);
                end
            end
            default:
            begin
                neg_next = neg_reg;
            end
        endcase
        // a new window length restarts the filter
        if (cfg_wr_en)
        begin
            len_next   = cfg_wr_data;
            ptr_next   = '0;
            valid_next = '0;
            sum_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mad_pkg::ST_IDLE;
            len_reg       <= mad_pkg::LEN_RESET;
            ptr_reg       <= '0;
            valid_reg     <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            ptr_reg       <= ptr_next;
            valid_reg     <= valid_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg        <= x_next;
        clear_reg    <= clear_next;
        neg_reg      <= neg_next;
        out_mean_reg <= out_mean_next;
        out_dev_reg  <= out_dev_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(mad_pkg::OUT_DATA_W - mad_pkg::SAMPLE_BITS - mad_pkg::DEV_W)'(0),
                            out_dev_reg, out_mean_reg};

endmodule

// ----- hw/rtl/moving_average_deviation.sv -----
`timescale 1ns / 1ps
// boxcar moving average with deviation of the newest sample
// s_axis carries one transaction per item: tuser selects push (0) or clear (1),
// tdata holds the signed 16-bit sample. m_axis returns one result per item:
// mean (sum of the window divided by the window length, truncated toward zero)
// and deviation (mean minus the pushed sample). cfg_wr_en/cfg_wr_data set the
// window length (1 to 64, reset value 8) and restart the filter; write it only
// while no item is in flight.
// the back end handles one item at a time and takes the next from the queue only
// after loading the result; a push runs the ring read, sum update, the 22-step
// bit-serial divider and the output load, a clear only the output load.
// a two-entry queue behind s_axis keeps accepting while the back end works;
// s_axis_tready drops while the queue holds two transactions.
// a registered output stage holds the result while m_axis_tready is low, and
// the back end waits with its next result until that one is taken.
// reset empties the queue, drops m_axis_tvalid, sets the window length to 8
// and zeroes the history (ring entries read as zero until written again).
module moving_average_deviation (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [mad_pkg::LEN_W-1:0]      cfg_wr_data,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [mad_pkg::IN_DATA_W-1:0]  s_axis_tdata,  // sample
    input  logic [0:0]                     s_axis_tuser,  // operation
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [mad_pkg::OUT_DATA_W-1:0] m_axis_tdata   // mean, deviation, zero pad
);

    mad_pkg::q_item_t q_item;
    logic             q_pop;

    mad_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_item        (q_item),
        .q_pop         (q_pop)
    );

    mad_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- hw/rtl/mad_checker.sv -----
`timescale 1ns / 1ps
`include "moving_average_deviation_assert.svh"

module mad_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [mad_pkg::OUT_DATA_W-1:0] m_axis_tdata
);

    // items accepted but not yet delivered
    logic [2:0] pending_reg, pending_next;
    logic       in_txn;
    logic       out_txn;

    assign in_txn  = s_axis_tvalid && s_axis_tready;
    assign out_txn = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        pending_next = pending_reg;
        if (in_txn && !out_txn)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (out_txn && !in_txn)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    `MAD_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, m_axis_tdata, "result dropped or changed while stalled")
    `MAD_ASSERT_IMPL(a_no_invented, m_axis_tvalid, pending_reg != 3'd0, "result with no item in flight")
    `MAD_ASSERT_IMPL(a_ready_low, !s_axis_tready, pending_reg >= 3'd2, "input stalled with queue not full")
    `MAD_ASSERT_IMPL(a_pending_max, 1'b1, pending_reg <= 3'd4, "more items in flight than storage")

endmodule

bind moving_average_deviation mad_checker u_mad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
